### design/cdl_pkg.sv
// Shared constants for the circular deque list: defaults, field widths, action and status codes.
`timescale 1ns / 1ps

package cdl_pkg;

    // Default geometry of the element store
    localparam int DEPTH_DEFAULT      = 128;
    localparam int ELEM_WIDTH_DEFAULT = 32;

    // Port field widths
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 8;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_AT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TAKE       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DROP       = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

endpackage

### design/circular_deque_list.sv
// Top level of the circular deque list: pointer and count control around the element store.
//
//   channel | direction | handshake            | fields
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | action, value, count
//   out     | output    | out_valid / out_stall| data, occupancy, status
//
// One transaction enters per cycle while in_stall is low; its result passes
// through stage one, where the store read is registered at the accepting
// edge, and then the output register. Head pointer and count update at the
// accepting edge, so each action touches the store in its own cycle and no forwarding is needed.
// Reset clears the head pointer and count; the store itself is not cleared.
// A stall on the output backs up through a two-entry pipeline to in_stall.
`timescale 1ns / 1ps

module circular_deque_list #(
    parameter int DEPTH      = cdl_pkg::DEPTH_DEFAULT,
    parameter int ELEM_WIDTH = cdl_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cdl_pkg::ACTION_W-1:0]  action,
    input  logic [cdl_pkg::VALUE_W-1:0]   value,
    input  logic [cdl_pkg::COUNT_W-1:0]   count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cdl_pkg::DATA_W-1:0]    data,
    output logic [cdl_pkg::OCC_W-1:0]     occupancy,
    output logic [cdl_pkg::STATUS_W-1:0]  status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > cdl_pkg::COUNT_W) ? CW : cdl_pkg::COUNT_W;
    localparam int XW = (ELEM_WIDTH > cdl_pkg::DATA_W) ? ELEM_WIDTH : cdl_pkg::DATA_W;

    localparam logic [PW:0]   DEPTH_IDX = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_IDX  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Fold a sum below twice the depth back into the store
    function automatic logic [PW-1:0] wrap_index(input logic [PW:0] sum);
        if (sum >= DEPTH_IDX)
        begin
            return PW'(sum - DEPTH_IDX);
        end
        return PW'(sum);
    endfunction

    // List state
    logic [PW-1:0] first_reg, first_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Stage one: store read in flight
    logic                         s1_valid_reg, s1_valid_next;
    logic [cdl_pkg::STATUS_W-1:0] s1_status_reg;
    logic [cdl_pkg::OCC_W-1:0]    s1_occ_reg;
    logic                         s1_rd_reg;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [cdl_pkg::DATA_W-1:0]   data_reg;
    logic [cdl_pkg::OCC_W-1:0]    occupancy_reg;
    logic [cdl_pkg::STATUS_W-1:0] status_reg;

    // Action decode
    logic [cdl_pkg::STATUS_W-1:0] op_status;
    logic                         op_rd;
    logic                         op_wr;
    logic [PW-1:0]                wr_addr;
    logic [PW-1:0]                rd_addr;
    logic [NW-1:0]                n_wide;
    logic [NW-1:0]                cnt_wide;
    logic [NW-1:0]                occ_wide;
    logic [PW:0]                  n_idx;
    logic [PW:0]                  cnt_idx;
    logic [XW-1:0]                value_wide;
    logic [XW-1:0]                rd_wide;
    logic [ELEM_WIDTH-1:0]        wr_data;
    logic [ELEM_WIDTH-1:0]        rd_data;

    // Handshake
    logic out_free;
    logic s1_move;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign n_wide     = NW'(count);
    assign cnt_wide   = NW'(cnt_reg);
    assign n_idx      = (PW + 1)'(count);
    assign cnt_idx    = (PW + 1)'(cnt_reg);
    assign value_wide = XW'(value);
    assign wr_data    = value_wide[ELEM_WIDTH-1:0];

    // Decode the action into pointer, count and store access
    always_comb
    begin
        first_next = first_reg;
        cnt_next   = cnt_reg;
        op_status  = cdl_pkg::STATUS_OK;
        op_rd      = 1'b0;
        op_wr      = 1'b0;
        wr_addr    = '0;
        rd_addr    = '0;
        case (action)
            cdl_pkg::ACT_PUSH_FRONT:
            begin
                if (cnt_reg == FULL_CNT)
                begin
                    op_status = cdl_pkg::STATUS_FULL;
                end
                else
                begin
                    first_next = (first_reg == '0) ? LAST_IDX : first_reg - PW'(1);
                    cnt_next   = cnt_reg + CW'(1);
                    op_wr      = 1'b1;
                    wr_addr    = first_next;
                end
            end
            cdl_pkg::ACT_PUSH_BACK:
            begin
                if (cnt_reg == FULL_CNT)
                begin
                    op_status = cdl_pkg::STATUS_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    op_wr    = 1'b1;
                    wr_addr  = wrap_index({1'b0, first_reg} + cnt_idx);
                end
            end
            cdl_pkg::ACT_POP_FRONT:
            begin
                if (cnt_reg == '0)
                begin
                    op_status = cdl_pkg::STATUS_EMPTY;
                end
                else
                begin
                    first_next = (first_reg == LAST_IDX) ? '0 : first_reg + PW'(1);
                    cnt_next   = cnt_reg - CW'(1);
                end
            end
            cdl_pkg::ACT_READ_AT:
            begin
                if (n_wide >= cnt_wide)
                begin
                    op_status = cdl_pkg::STATUS_RANGE;
                end
                else
                begin
                    op_rd   = 1'b1;
                    rd_addr = wrap_index({1'b0, first_reg} + n_idx);
                end
            end
            cdl_pkg::ACT_TAKE:
            begin
                if (n_wide < cnt_wide)
                begin
                    cnt_next = CW'(n_wide);
                end
            end
            cdl_pkg::ACT_DROP:
            begin
                if (n_wide == '0)
                begin
                    cnt_next = cnt_reg;
                end
                else if (n_wide >= cnt_wide)
                begin
                    cnt_next   = '0;
                    first_next = '0;
                end
                else
                begin
                    first_next = wrap_index({1'b0, first_reg} + n_idx);
                    cnt_next   = cnt_reg - CW'(n_wide);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign occ_wide = NW'(cnt_next);

    cdl_store #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH),
        .AW         (PW)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && op_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept && op_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance pointer and count on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Pipeline valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold stage-one payload while the store read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= op_status;
            s1_occ_reg    <= occ_wide[cdl_pkg::OCC_W-1:0];
            s1_rd_reg     <= op_rd;
        end
    end

    assign rd_wide = XW'(rd_data);

    // Move the finished transaction into the output register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            data_reg      <= s1_rd_reg ? rd_wide[cdl_pkg::DATA_W-1:0] : '0;
            occupancy_reg <= s1_occ_reg;
            status_reg    <= s1_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign occupancy = occupancy_reg;
    assign status    = status_reg;

endmodule

### design/cdl_store.sv
// Element store of the circular deque list: one write port, one registered read port.
`timescale 1ns / 1ps

module cdl_store #(
    parameter int DEPTH      = cdl_pkg::DEPTH_DEFAULT,
    parameter int ELEM_WIDTH = cdl_pkg::ELEM_WIDTH_DEFAULT,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [ELEM_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [ELEM_WIDTH-1:0] rd_data
);

    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    // Write the entry on request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Load read data only on a read, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
